FILE: rtl/core/bmpc_pkg.sv
// ============================================================================
// bmpc_pkg: shared types and constants of the blind motor position controller
// Holds item field widths, code values, register indexes and reset values.
// ============================================================================
package bmpc_pkg;

  localparam int FUNC_W = 2;
  localparam int CMD_W  = 4;
  localparam int OUT_POS_W = 16;
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_PULSE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CMD   = 2'd2;

  localparam logic [CMD_W-1:0] CMD_STOP       = 4'd0;
  localparam logic [CMD_W-1:0] CMD_GO_TOP     = 4'd1;
  localparam logic [CMD_W-1:0] CMD_GO_MIDDLE  = 4'd2;
  localparam logic [CMD_W-1:0] CMD_GO_BOTTOM  = 4'd3;
  localparam logic [CMD_W-1:0] CMD_SET_TOP    = 4'd4;
  localparam logic [CMD_W-1:0] CMD_SET_MIDDLE = 4'd5;
  localparam logic [CMD_W-1:0] CMD_SET_BOTTOM = 4'd6;
  localparam logic [CMD_W-1:0] CMD_NUDGE_UP   = 4'd7;
  localparam logic [CMD_W-1:0] CMD_NUDGE_DOWN = 4'd8;
  localparam logic [CMD_W-1:0] CMD_TOGGLE     = 4'd9;
  localparam logic [CMD_W-1:0] CMD_INVERT     = 4'd10;

  localparam logic [2:0] PH_STOPPED  = 3'd0;
  localparam logic [2:0] PH_STOPPING = 3'd1;
  localparam logic [2:0] PH_BRAKING  = 3'd2;
  localparam logic [2:0] PH_UP       = 3'd3;
  localparam logic [2:0] PH_DOWN     = 3'd4;

  localparam logic [1:0] TR_STOPPED = 2'd0;
  localparam logic [1:0] TR_RISING  = 2'd1;
  localparam logic [1:0] TR_FALLING = 2'd2;

  localparam logic [1:0] GK_NONE   = 2'd0;
  localparam logic [1:0] GK_TOP    = 2'd1;
  localparam logic [1:0] GK_MIDDLE = 2'd2;
  localparam logic [1:0] GK_BOTTOM = 2'd3;

  localparam logic [2:0] ACT_NONE   = 3'd0;
  localparam logic [2:0] ACT_STOP   = 3'd1;
  localparam logic [2:0] ACT_TOP    = 3'd2;
  localparam logic [2:0] ACT_MIDDLE = 3'd3;
  localparam logic [2:0] ACT_BOTTOM = 3'd4;
  localparam logic [2:0] ACT_FUP    = 3'd5;
  localparam logic [2:0] ACT_FDOWN  = 3'd6;
  localparam logic [2:0] ACT_TOGGLE = 3'd7;

  localparam logic [1:0] REG_SETTLE = 2'd0;
  localparam logic [1:0] REG_FORCE  = 2'd1;
  localparam logic [1:0] REG_IGNORE = 2'd2;
  localparam logic [1:0] REG_SAVE   = 2'd3;

  localparam logic [9:0]  SETTLE_RST = 10'd50;
  localparam logic [14:0] FORCE_RST  = 15'd28;
  localparam logic [9:0]  IGNORE_RST = 10'd3;
  localparam logic [15:0] SAVE_RST   = 16'd30000;

  localparam logic [9:0]  SETTLE_MAX = 10'h3FF;
  localparam logic [15:0] SAVE_MAX   = 16'hFFFF;

  localparam int POS_RST_VAL    = 10;
  localparam int TOP_RST_VAL    = 28;
  localparam int FAR_STOP_VAL   = 32000;
  localparam int TARGET_RST_VAL = 15;

  typedef struct packed {
    logic [9:0]  settle_ms;
    logic [14:0] force_distance;
    logic [9:0]  ignore_distance;
    logic [15:0] save_delay_ms;
  } cfg_t;

  typedef struct packed {
    logic                 motor_on;
    logic                 motor_dir;
    logic [OUT_POS_W-1:0] position;
    logic [1:0]           blind_status;
    logic [2:0]           motor_phase;
    logic                 save_request;
  } result_t;

endpackage

FILE: rtl/core/bmpc_if.sv
// ============================================================================
// bmpc_if: valid/ready channel interfaces of the blind motor controller
// One interface for input items and one for result items.
// ============================================================================
interface bmpc_item_if;
  import bmpc_pkg::*;
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [CMD_W-1:0]  command;
  logic              limit_active;
  modport source(output valid, func, command, limit_active, input ready);
  modport sink(input valid, func, command, limit_active, output ready);
endinterface

interface bmpc_result_if;
  import bmpc_pkg::*;
  logic                        valid;
  logic                        ready;
  logic                        motor_on;
  logic                        motor_dir;
  logic signed [OUT_POS_W-1:0] position;
  logic [1:0]                  blind_status;
  logic [2:0]                  motor_phase;
  logic                        save_request;
  modport source(output valid, motor_on, motor_dir, position, blind_status, motor_phase,
                 save_request, input ready);
  modport sink(input valid, motor_on, motor_dir, position, blind_status, motor_phase,
               save_request, output ready);
endinterface

FILE: rtl/core/bmpc_cfg.sv
// ============================================================================
// bmpc_cfg: configuration register file
// APB-style write and read access to the four timing and distance registers.
// ============================================================================
module bmpc_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bmpc_pkg::ADDR_W-1:0]    paddr,
  input  logic [bmpc_pkg::DATA_W-1:0]    pwdata,
  output logic [bmpc_pkg::DATA_W-1:0]    prdata,
  output logic                           pready,
  output bmpc_pkg::cfg_t                 cfg
);
  import bmpc_pkg::*;

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.settle_ms       <= SETTLE_RST;
      cfg.force_distance  <= FORCE_RST;
      cfg.ignore_distance <= IGNORE_RST;
      cfg.save_delay_ms   <= SAVE_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_SETTLE: cfg.settle_ms       <= pwdata[9:0];
        REG_FORCE:  cfg.force_distance  <= pwdata[14:0];
        REG_IGNORE: cfg.ignore_distance <= pwdata[9:0];
        REG_SAVE:   cfg.save_delay_ms   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SETTLE: prdata = DATA_W'(cfg.settle_ms);
      REG_FORCE:  prdata = DATA_W'(cfg.force_distance);
      REG_IGNORE: prdata = DATA_W'(cfg.ignore_distance);
      REG_SAVE:   prdata = DATA_W'(cfg.save_delay_ms);
      default:    prdata = '0;
    endcase
  end

endmodule

FILE: rtl/core/bmpc_engine.sv
// ============================================================================
// bmpc_engine: controller state and its single-pass update
// Applies one item to position, stops, timers, motor sequencer and travel
// machine, and forms the result item from the updated state.
// ============================================================================
module bmpc_engine #(
  parameter int POS_WIDTH = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        fire,
  input  logic [bmpc_pkg::FUNC_W-1:0] func,
  input  logic [bmpc_pkg::CMD_W-1:0]  command,
  input  logic                        limit_active,
  input  bmpc_pkg::cfg_t              cfg,
  output bmpc_pkg::result_t           res_next
);
  import bmpc_pkg::*;

  localparam logic [POS_WIDTH-1:0] POS_RST    = POS_WIDTH'(POS_RST_VAL);
  localparam logic [POS_WIDTH-1:0] TOP_RST    = POS_WIDTH'(TOP_RST_VAL);
  localparam logic [POS_WIDTH-1:0] FAR_RST    = POS_WIDTH'(-FAR_STOP_VAL);
  localparam logic [POS_WIDTH-1:0] TARGET_RST = POS_WIDTH'(TARGET_RST_VAL);
  localparam logic [POS_WIDTH-1:0] POS_ONE    = POS_WIDTH'(1);

  logic [POS_WIDTH-1:0] position_count, position_count_next;
  logic [POS_WIDTH-1:0] stop_hi, stop_hi_next;
  logic [POS_WIDTH-1:0] stop_mid, stop_mid_next;
  logic [POS_WIDTH-1:0] stop_lo, stop_lo_next;
  logic [POS_WIDTH-1:0] target_position, target_position_next;
  logic                 up_direction, up_direction_next;
  logic [1:0]           travel_status, travel_status_next;
  logic [1:0]           last_goal_kind, last_goal_kind_next;
  logic [2:0]           motor_current, motor_current_next;
  logic [2:0]           motor_wanted, motor_wanted_next;
  logic                 run_relay, run_relay_next;
  logic                 dir_relay, dir_relay_next;
  logic [9:0]           settle_elapsed, settle_elapsed_next;
  logic [9:0]           limit_ignore_left, limit_ignore_left_next;
  logic                 save_pending, save_pending_next;
  logic [15:0]          save_elapsed, save_elapsed_next;

  logic [POS_WIDTH-1:0] force_step;
  logic [2:0]           act;
  logic                 save_req;
  logic                 settled;

  assign force_step = POS_WIDTH'(cfg.force_distance);

  always_comb begin
    position_count_next    = position_count;
    stop_hi_next           = stop_hi;
    stop_mid_next          = stop_mid;
    stop_lo_next           = stop_lo;
    target_position_next   = target_position;
    up_direction_next      = up_direction;
    travel_status_next     = travel_status;
    last_goal_kind_next    = last_goal_kind;
    motor_current_next     = motor_current;
    motor_wanted_next      = motor_wanted;
    run_relay_next         = run_relay;
    dir_relay_next         = dir_relay;
    settle_elapsed_next    = settle_elapsed;
    limit_ignore_left_next = limit_ignore_left;
    save_pending_next      = save_pending;
    save_elapsed_next      = save_elapsed;
    act                    = ACT_NONE;
    save_req               = 1'b0;

    case (func)
      FUNC_TICK: begin
        if (settle_elapsed != SETTLE_MAX) begin
          settle_elapsed_next = settle_elapsed + 10'd1;
        end
        if (save_pending && (save_elapsed != SAVE_MAX)) begin
          save_elapsed_next = save_elapsed + 16'd1;
        end
      end
      FUNC_PULSE: begin
        if (dir_relay == up_direction) begin
          position_count_next = position_count + POS_ONE;
        end else begin
          position_count_next = position_count - POS_ONE;
        end
        if (limit_ignore_left != '0) begin
          limit_ignore_left_next = limit_ignore_left - 10'd1;
        end
        save_pending_next = 1'b1;
        save_elapsed_next = '0;
      end
      default: ;
    endcase

    if (save_pending_next && (save_elapsed_next >= cfg.save_delay_ms)) begin
      save_req          = 1'b1;
      save_pending_next = 1'b0;
    end

    if (func == FUNC_CMD) begin
      unique case (command)
        CMD_STOP:       act = ACT_STOP;
        CMD_GO_TOP:     act = ACT_TOP;
        CMD_GO_MIDDLE:  act = ACT_MIDDLE;
        CMD_GO_BOTTOM:  act = ACT_BOTTOM;
        CMD_SET_TOP: begin
          stop_hi_next      = position_count_next;
          save_pending_next = 1'b1;
          save_elapsed_next = '0;
        end
        CMD_SET_MIDDLE: begin
          stop_mid_next     = position_count_next;
          save_pending_next = 1'b1;
          save_elapsed_next = '0;
        end
        CMD_SET_BOTTOM: begin
          stop_lo_next      = position_count_next;
          save_pending_next = 1'b1;
          save_elapsed_next = '0;
        end
        CMD_NUDGE_UP:   act = ACT_FUP;
        CMD_NUDGE_DOWN: act = ACT_FDOWN;
        CMD_TOGGLE:     act = ACT_TOGGLE;
        CMD_INVERT: begin
          up_direction_next = ~up_direction;
          save_pending_next = 1'b1;
          save_elapsed_next = '0;
        end
        default: ;
      endcase
    end

    // Motor sequencer: at most one relay step per item.
    settled = (settle_elapsed_next >= cfg.settle_ms);
    if (motor_wanted != motor_current) begin
      unique case (motor_current) inside
        PH_UP, PH_DOWN: begin
          run_relay_next      = 1'b0;
          motor_current_next  = PH_STOPPING;
          settle_elapsed_next = '0;
        end
        PH_STOPPING: begin
          if (settled) begin
            dir_relay_next      = ~dir_relay;
            motor_current_next  = PH_BRAKING;
            settle_elapsed_next = '0;
          end
        end
        PH_BRAKING: begin
          if (settled) begin
            dir_relay_next      = 1'b0;
            motor_current_next  = PH_STOPPED;
            settle_elapsed_next = '0;
          end
        end
        default: begin
          if (settled) begin
            if ((motor_wanted == PH_UP) && (dir_relay != up_direction_next)) begin
              dir_relay_next = up_direction_next;
            end else if ((motor_wanted == PH_DOWN) && (dir_relay == up_direction_next)) begin
              dir_relay_next = ~up_direction_next;
            end else begin
              if (motor_wanted != PH_STOPPED) begin
                motor_current_next = motor_wanted;
                run_relay_next     = 1'b1;
              end
              settle_elapsed_next = '0;
            end
          end
        end
      endcase
    end

    // Travel machine.
    if (act == ACT_TOGGLE) begin
      if (travel_status != TR_STOPPED) begin
        act = ACT_STOP;
      end else if (last_goal_kind == GK_TOP) begin
        act = ACT_MIDDLE;
      end else begin
        act = ACT_TOP;
      end
    end

    if (act == ACT_STOP) begin
      motor_wanted_next  = PH_STOPPED;
      travel_status_next = TR_STOPPED;
    end else begin
      if (act != ACT_NONE) begin
        case (act)
          ACT_TOP: begin
            last_goal_kind_next  = GK_TOP;
            target_position_next = stop_hi_next;
          end
          ACT_MIDDLE: begin
            last_goal_kind_next  = GK_MIDDLE;
            target_position_next = stop_mid_next;
          end
          ACT_BOTTOM: begin
            last_goal_kind_next  = GK_BOTTOM;
            target_position_next = stop_lo_next;
          end
          ACT_FUP:   target_position_next = position_count_next + force_step;
          default:   target_position_next = position_count_next - force_step;
        endcase
        if ($signed(position_count_next) < $signed(target_position_next)) begin
          travel_status_next = TR_RISING;
          if (limit_active) begin
            limit_ignore_left_next = cfg.ignore_distance;
          end
          motor_wanted_next = PH_UP;
        end else if (($signed(position_count_next) > $signed(target_position_next)) &&
                     !limit_active) begin
          travel_status_next = TR_FALLING;
          motor_wanted_next  = PH_DOWN;
        end else begin
          travel_status_next = TR_STOPPED;
          motor_wanted_next  = PH_STOPPED;
        end
      end
      if (motor_wanted_next == motor_current_next) begin
        if (travel_status_next == TR_STOPPED) begin
          run_relay_next = 1'b0;
        end else if (travel_status_next == TR_FALLING) begin
          if (limit_active ||
              ($signed(position_count_next) <= $signed(target_position_next))) begin
            motor_wanted_next  = PH_STOPPED;
            travel_status_next = TR_STOPPED;
          end
        end else if (travel_status_next == TR_RISING) begin
          if ((limit_active && (limit_ignore_left_next == '0)) ||
              ($signed(position_count_next) >= $signed(target_position_next))) begin
            motor_wanted_next  = PH_STOPPED;
            travel_status_next = TR_STOPPED;
          end
        end
      end
    end

    res_next.motor_on     = run_relay_next;
    res_next.motor_dir    = dir_relay_next;
    res_next.position     = OUT_POS_W'($signed(position_count_next));
    res_next.blind_status = travel_status_next;
    res_next.motor_phase  = motor_current_next;
    res_next.save_request = save_req;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position_count    <= POS_RST;
      stop_hi           <= TOP_RST;
      stop_mid          <= FAR_RST;
      stop_lo           <= FAR_RST;
      target_position   <= TARGET_RST;
      up_direction      <= 1'b0;
      travel_status     <= TR_STOPPED;
      last_goal_kind    <= GK_NONE;
      motor_current     <= PH_STOPPED;
      motor_wanted      <= PH_STOPPED;
      run_relay         <= 1'b0;
      dir_relay         <= 1'b0;
      settle_elapsed    <= SETTLE_MAX;
      limit_ignore_left <= '0;
      save_pending      <= 1'b0;
      save_elapsed      <= '0;
    end else if (fire) begin
      position_count    <= position_count_next;
      stop_hi           <= stop_hi_next;
      stop_mid          <= stop_mid_next;
      stop_lo           <= stop_lo_next;
      target_position   <= target_position_next;
      up_direction      <= up_direction_next;
      travel_status     <= travel_status_next;
      last_goal_kind    <= last_goal_kind_next;
      motor_current     <= motor_current_next;
      motor_wanted      <= motor_wanted_next;
      run_relay         <= run_relay_next;
      dir_relay         <= dir_relay_next;
      settle_elapsed    <= settle_elapsed_next;
      limit_ignore_left <= limit_ignore_left_next;
      save_pending      <= save_pending_next;
      save_elapsed      <= save_elapsed_next;
    end
  end

endmodule

FILE: rtl/core/blind_motor_position_controller_core.sv
// ============================================================================
// blind_motor_position_controller_core: blind motor position controller
// Input register, single-pass state update and result register.
//
//   Channel  Kind          Direction  Carries
//   item     valid/ready   in         func, command, limit_active
//   result   valid/ready   out        relays, position, status, phase, save
//   APB      psel/penable  in/out     settle, force, ignore, save delay
//
// One item per cycle is sustained while results are taken; an item is captured
// in the input register and its result is offered from the result register.
// Synchronous reset clears the state to its reset values and empties both
// registers. A stalled result holds the input register, and the item
// channel then accepts only when the result register drains.
// ============================================================================
module blind_motor_position_controller_core #(
  parameter int POS_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  bmpc_item_if.sink                    item,
  bmpc_result_if.source                result,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bmpc_pkg::ADDR_W-1:0]  paddr,
  input  logic [bmpc_pkg::DATA_W-1:0]  pwdata,
  output logic [bmpc_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);
  import bmpc_pkg::*;

  cfg_t              cfg;
  result_t           res_next;
  result_t           res_q;
  logic              in_valid;
  logic [FUNC_W-1:0] in_func;
  logic [CMD_W-1:0]  in_command;
  logic              in_limit;
  logic              out_valid;
  logic              advance;

  bmpc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bmpc_engine #(.POS_WIDTH(POS_WIDTH)) u_engine (
    .clk          (clk),
    .rst          (rst),
    .fire         (advance),
    .func         (in_func),
    .command      (in_command),
    .limit_active (in_limit),
    .cfg          (cfg),
    .res_next     (res_next)
  );

  assign advance    = in_valid && (!out_valid || result.ready);
  assign item.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (item.ready) begin
      in_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      in_func    <= item.func;
      in_command <= item.command;
      in_limit   <= item.limit_active;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= res_next;
    end
  end

  assign result.valid        = out_valid;
  assign result.motor_on     = res_q.motor_on;
  assign result.motor_dir    = res_q.motor_dir;
  assign result.position     = res_q.position;
  assign result.blind_status = res_q.blind_status;
  assign result.motor_phase  = res_q.motor_phase;
  assign result.save_request = res_q.save_request;

endmodule

FILE: rtl/core/bmpc_checker.sv
// ============================================================================
// bmpc_checker: port-level checks of the blind motor controller
// Watches the channels of the top level and is attached to it by bind.
// ============================================================================
module bmpc_checker (
  input logic        clk,
  input logic        rst,
  input logic        item_ready,
  input logic        result_valid,
  input logic        result_ready,
  input logic        motor_on,
  input logic        motor_dir,
  input logic [15:0] position,
  input logic [2:0]  motor_phase
);
  import bmpc_pkg::*;

  // The run relay is closed only while the motor runs up or down.
  a_run_phase: assert property (@(posedge clk) disable iff (rst)
    (result_valid && motor_on) |-> (motor_phase == PH_UP || motor_phase == PH_DOWN))
    else $error("motor_on set outside a running phase");

  // With no result waiting the block must take a new transaction.
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> item_ready)
    else $error("item not ready while result register is empty");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !result_valid)
    else $error("result valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=>
      (result_valid && $stable(position) && $stable(motor_on) && $stable(motor_dir)))
    else $error("stalled result transaction changed");

endmodule

bind blind_motor_position_controller_core bmpc_checker u_bmpc_checker (
  .clk          (clk),
  .rst          (rst),
  .item_ready   (item.ready),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .motor_on     (result.motor_on),
  .motor_dir    (result.motor_dir),
  .position     (result.position),
  .motor_phase  (result.motor_phase)
);

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// ============================================================================
// testbench: self-checking bench for the blind motor position controller
// A directed table of ticks, pulses, commands and idle items opens the run, then random
// traffic runs under several register settings written over the APB port.
// Every result is compared field by field with a table entry or with an in-bench model
// of the travel machine, the relay sequencer and the save timer.
// ============================================================================
module testbench;
  import bmpc_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_IDLE    = 2'd3;
  localparam logic [CMD_W-1:0]  CMD_SPARE_LO = 4'd11;
  localparam logic [CMD_W-1:0]  CMD_SPARE_HI = 4'd15;
  localparam int DIRECTED_ROWS  = 24;
  localparam int SETTING_COUNT  = 6;
  localparam int LONG_HOLD      = 120;
  localparam int STALL_WINDOW   = 40;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam result_t UNCHECKED = '0;

  typedef struct packed {
    logic [FUNC_W-1:0] fn;
    logic [CMD_W-1:0]  cmd;
    logic              lim;
    logic              known;
    result_t           exp;
  } row_t;

  typedef enum {STALL_NONE, STALL_HALF, STALL_HEAVY} stall_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic pready;

  bmpc_item_if   item_ch();
  bmpc_result_if result_ch();

  blind_motor_position_controller_core dut (
    .clk(clk),
    .rst(rst),
    .item(item_ch),
    .result(result_ch),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #5 clk = ~clk;

  // Model state.
  cfg_t               cfg_model;
  logic signed [15:0] pos_cnt;
  logic signed [15:0] hi_stop;
  logic signed [15:0] mid_stop;
  logic signed [15:0] bot_stop;
  logic signed [15:0] tgt_pos;
  logic               up_dir;
  logic [1:0]         travel;
  logic [1:0]         goal_kind;
  logic [2:0]         ph_cur;
  logic [2:0]         ph_want;
  logic               run_rly;
  logic               dir_rly;
  logic [9:0]         settle_cnt;
  logic [9:0]         ignore_left;
  logic               save_pend;
  logic [15:0]        save_cnt;

  result_t     pending_results[$];
  result_t     front;
  row_t        plan[DIRECTED_ROWS];
  cfg_t        settings[SETTING_COUNT];
  int          phase_items[SETTING_COUNT] = '{150, 100, 300, 300, 300, 300};
  int          burst_left = 0;
  int          mismatch_count = 0;
  int          items_sent = 0;
  int          results_checked = 0;
  int          saves_seen = 0;
  int          running_seen = 0;
  int          idle_cycles = 0;
  int          ph;
  int          n;
  logic        hold_pending = 1'b0;
  stall_mode_t stall_mode;

  task automatic reset_model();
    cfg_model.settle_ms       = SETTLE_RST;
    cfg_model.force_distance  = FORCE_RST;
    cfg_model.ignore_distance = IGNORE_RST;
    cfg_model.save_delay_ms   = SAVE_RST;
    pos_cnt     = 16'(POS_RST_VAL);
    hi_stop     = 16'(TOP_RST_VAL);
    mid_stop    = 16'(-FAR_STOP_VAL);
    bot_stop    = 16'(-FAR_STOP_VAL);
    tgt_pos     = 16'(TARGET_RST_VAL);
    up_dir      = 1'b0;
    travel      = TR_STOPPED;
    goal_kind   = GK_NONE;
    ph_cur      = PH_STOPPED;
    ph_want     = PH_STOPPED;
    run_rly     = 1'b0;
    dir_rly     = 1'b0;
    settle_cnt  = SETTLE_MAX;
    ignore_left = '0;
    save_pend   = 1'b0;
    save_cnt    = '0;
  endtask

  function automatic void note_change();
    save_pend = 1'b1;
    save_cnt  = '0;
  endfunction

  function automatic void step_relays();
    if (ph_want == ph_cur) return;
    case (ph_cur) inside
      PH_UP, PH_DOWN: begin
        run_rly    = 1'b0;
        ph_cur     = PH_STOPPING;
        settle_cnt = '0;
      end
      PH_STOPPING: begin
        if (settle_cnt >= cfg_model.settle_ms) begin
          dir_rly    = ~dir_rly;
          ph_cur     = PH_BRAKING;
          settle_cnt = '0;
        end
      end
      PH_BRAKING: begin
        if (settle_cnt >= cfg_model.settle_ms) begin
          dir_rly    = 1'b0;
          ph_cur     = PH_STOPPED;
          settle_cnt = '0;
        end
      end
      default: begin
        if (settle_cnt >= cfg_model.settle_ms) begin
          // The direction relay is set on an earlier transaction than the one on which the run relay closes.
          if (ph_want == PH_UP && dir_rly != up_dir) begin
            dir_rly = up_dir;
          end else if (ph_want == PH_DOWN && dir_rly == up_dir) begin
            dir_rly = ~up_dir;
          end else begin
            if (ph_want != PH_STOPPED) begin
              ph_cur  = ph_want;
              run_rly = 1'b1;
            end
            settle_cnt = '0;
          end
        end
      end
    endcase
  endfunction

  function automatic void step_travel(logic [2:0] act, logic lim);
    logic signed [15:0] here;
    here = pos_cnt;
    if (act == ACT_TOGGLE) begin
      if (travel != TR_STOPPED) act = ACT_STOP;
      else if (goal_kind == GK_TOP) act = ACT_MIDDLE;
      else act = ACT_TOP;
    end
    if (act == ACT_STOP) begin
      ph_want = PH_STOPPED;
      travel  = TR_STOPPED;
      return;
    end
    if (act != ACT_NONE) begin
      case (act)
        ACT_TOP: begin
          goal_kind = GK_TOP;
          tgt_pos   = hi_stop;
        end
        ACT_MIDDLE: begin
          goal_kind = GK_MIDDLE;
          tgt_pos   = mid_stop;
        end
        ACT_BOTTOM: begin
          goal_kind = GK_BOTTOM;
          tgt_pos   = bot_stop;
        end
        ACT_FUP:  tgt_pos = pos_cnt + {1'b0, cfg_model.force_distance};
        default:  tgt_pos = pos_cnt - {1'b0, cfg_model.force_distance};
      endcase
      if (here < tgt_pos) begin
        travel = TR_RISING;
        if (lim) ignore_left = cfg_model.ignore_distance;
        ph_want = PH_UP;
      end else if (here > tgt_pos && !lim) begin
        travel  = TR_FALLING;
        ph_want = PH_DOWN;
      end else begin
        travel  = TR_STOPPED;
        ph_want = PH_STOPPED;
      end
    end
    if (ph_want != ph_cur) return;
    if (travel == TR_STOPPED) begin
      run_rly = 1'b0;
    end else if (travel == TR_FALLING) begin
      if (lim || here <= tgt_pos) begin
        ph_want = PH_STOPPED;
        travel  = TR_STOPPED;
      end
    end else if (travel == TR_RISING) begin
      if ((lim && ignore_left == 0) || here >= tgt_pos) begin
        ph_want = PH_STOPPED;
        travel  = TR_STOPPED;
      end
    end
  endfunction

  function automatic result_t advance_controller(logic [FUNC_W-1:0] fn, logic [CMD_W-1:0] cmd,
                                                 logic lim);
    logic [2:0] act;
    result_t    r;
    act = ACT_NONE;
    r   = '0;
    if (fn == FUNC_TICK) begin
      if (settle_cnt != SETTLE_MAX) settle_cnt = settle_cnt + 1'b1;
      if (save_pend && save_cnt != SAVE_MAX) save_cnt = save_cnt + 1'b1;
    end else if (fn == FUNC_PULSE) begin
      pos_cnt = (dir_rly == up_dir) ? pos_cnt + 16'sd1 : pos_cnt - 16'sd1;
      if (ignore_left != 0) ignore_left = ignore_left - 1'b1;
      note_change();
    end
    if (save_pend && save_cnt >= cfg_model.save_delay_ms) begin
      r.save_request = 1'b1;
      save_pend      = 1'b0;
    end
    if (fn == FUNC_CMD) begin
      case (cmd)
        CMD_STOP:       act = ACT_STOP;
        CMD_GO_TOP:     act = ACT_TOP;
        CMD_GO_MIDDLE:  act = ACT_MIDDLE;
        CMD_GO_BOTTOM:  act = ACT_BOTTOM;
        CMD_SET_TOP: begin
          hi_stop = pos_cnt;
          note_change();
        end
        CMD_SET_MIDDLE: begin
          mid_stop = pos_cnt;
          note_change();
        end
        CMD_SET_BOTTOM: begin
          bot_stop = pos_cnt;
          note_change();
        end
        CMD_NUDGE_UP:   act = ACT_FUP;
        CMD_NUDGE_DOWN: act = ACT_FDOWN;
        CMD_TOGGLE:     act = ACT_TOGGLE;
        CMD_INVERT: begin
          up_dir = ~up_dir;
          note_change();
        end
        default: ;
      endcase
    end
    step_relays();
    step_travel(act, lim);
    r.motor_on     = run_rly;
    r.motor_dir    = dir_rly;
    r.position     = pos_cnt;
    r.blind_status = travel;
    r.motor_phase  = ph_cur;
    return r;
  endfunction

  function automatic row_t random_item();
    row_t        r;
    int unsigned pick;
    r    = '0;
    pick = $urandom_range(99, 0);
    if (pick < 48) r.fn = FUNC_TICK;
    else if (pick < 83) r.fn = FUNC_PULSE;
    else if (pick < 98) r.fn = FUNC_CMD;
    else r.fn = FUNC_IDLE;
    if ($urandom_range(19, 0) == 0) r.cmd = CMD_W'($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO));
    else r.cmd = CMD_W'($urandom_range(CMD_INVERT, CMD_STOP));
    r.lim = ($urandom_range(9, 0) == 0);
    return r;
  endfunction

  task automatic offer_item(row_t r);
    int unsigned gap;
    result_t     predicted;
    if (burst_left == 0) begin
      burst_left = $urandom_range(24, 1);
      gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(8, 1);
      if (gap != 0) begin
        item_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    item_ch.valid        <= 1'b1;
    item_ch.func         <= r.fn;
    item_ch.command      <= r.cmd;
    item_ch.limit_active <= r.lim;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    predicted = advance_controller(r.fn, r.cmd, r.lim);
    pending_results.push_back(r.known ? r.exp : predicted);
    items_sent++;
  endtask

  task automatic wait_drained();
    item_ch.valid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apply_settings(cfg_t c);
    int          i;
    logic [1:0]  idx;
    logic [31:0] data;
    for (i = 0; i < 4; i++) begin
      idx = i[1:0];
      case (idx)
        REG_SETTLE: data = 32'(c.settle_ms);
        REG_FORCE:  data = 32'(c.force_distance);
        REG_IGNORE: data = 32'(c.ignore_distance);
        REG_SAVE:   data = 32'(c.save_delay_ms);
        default:    data = '0;
      endcase
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= data;
      @(posedge clk);
      penable <= 1'b1;
      @(posedge clk);
      while (!pready) @(posedge clk);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cfg_model = c;
  endtask

  function automatic void check_field(string name, logic signed [31:0] want,
                                      logic signed [31:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t ns: result transaction with no outstanding prediction", $time);
        mismatch_count++;
      end else begin
        front = pending_results.pop_front();
        check_field("motor_on", 32'(front.motor_on), 32'(result_ch.motor_on));
        check_field("motor_dir", 32'(front.motor_dir), 32'(result_ch.motor_dir));
        check_field("position", 32'($signed(front.position)), 32'(result_ch.position));
        check_field("blind_status", 32'(front.blind_status), 32'(result_ch.blind_status));
        check_field("motor_phase", 32'(front.motor_phase), 32'(result_ch.motor_phase));
        check_field("save_request", 32'(front.save_request), 32'(result_ch.save_request));
        results_checked++;
        if (front.save_request) saves_seen++;
        if (front.motor_on) running_seen++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) ||
        (psel && penable)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("%0t ns: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    result_ch.ready <= 1'b0;
    wait (!rst);
    forever begin
      stall_mode = stall_mode_t'($urandom_range(2, 0));
      repeat (STALL_WINDOW) begin
        if (hold_pending) begin
          hold_pending = 1'b0;
          result_ch.ready <= 1'b0;
          repeat (LONG_HOLD) @(posedge clk);
        end
        case (stall_mode)
          STALL_NONE: result_ch.ready <= 1'b1;
          STALL_HALF: result_ch.ready <= 1'($urandom_range(1, 0));
          default:    result_ch.ready <= ($urandom_range(3, 0) == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  initial begin
    item_ch.valid        <= 1'b0;
    item_ch.func         <= FUNC_TICK;
    item_ch.command      <= CMD_STOP;
    item_ch.limit_active <= 1'b0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    reset_model();

    plan = '{
      '{FUNC_TICK,  CMD_STOP,       1'b0, 1'b1, '{1'b0, 1'b0, 16'd10, TR_STOPPED, PH_STOPPED, 1'b0}},
      '{FUNC_PULSE, CMD_STOP,       1'b0, 1'b1, '{1'b0, 1'b0, 16'd11, TR_STOPPED, PH_STOPPED, 1'b0}},
      '{FUNC_CMD,   CMD_GO_TOP,     1'b0, 1'b1, '{1'b0, 1'b0, 16'd11, TR_RISING, PH_STOPPED, 1'b0}},
      '{FUNC_TICK,  CMD_STOP,       1'b0, 1'b1, '{1'b1, 1'b0, 16'd11, TR_RISING, PH_UP, 1'b0}},
      '{FUNC_PULSE, CMD_STOP,       1'b0, 1'b1, '{1'b1, 1'b0, 16'd12, TR_RISING, PH_UP, 1'b0}},
      '{FUNC_CMD,   CMD_STOP,       1'b0, 1'b1, '{1'b1, 1'b0, 16'd12, TR_STOPPED, PH_UP, 1'b0}},
      '{FUNC_TICK,  CMD_STOP,       1'b0, 1'b1, '{1'b0, 1'b0, 16'd12, TR_STOPPED, PH_STOPPING,
                                                  1'b0}},
      '{FUNC_IDLE,  CMD_GO_TOP,     1'b1, 1'b0, UNCHECKED},
      '{FUNC_CMD,   CMD_SPARE_LO,   1'b0, 1'b0, UNCHECKED},
      '{FUNC_CMD,   CMD_SPARE_HI,   1'b1, 1'b0, UNCHECKED},
      '{FUNC_CMD,   CMD_SET_TOP,    1'b0, 1'b0, UNCHECKED},
      '{FUNC_CMD,   CMD_SET_MIDDLE, 1'b0, 1'b0, UNCHECKED},
      '{FUNC_CMD,   CMD_SET_BOTTOM, 1'b0, 1'b0, UNCHECKED},
      '{FUNC_CMD,   CMD_INVERT,     1'b0, 1'b0, UNCHECKED},
      '{FUNC_CMD,   CMD_NUDGE_UP,   1'b1, 1'b0, UNCHECKED},
      '{FUNC_CMD,   CMD_NUDGE_DOWN, 1'b0, 1'b0, UNCHECKED},
      '{FUNC_CMD,   CMD_TOGGLE,     1'b0, 1'b0, UNCHECKED},
      '{FUNC_CMD,   CMD_GO_MIDDLE,  1'b0, 1'b0, UNCHECKED},
      '{FUNC_CMD,   CMD_GO_BOTTOM,  1'b1, 1'b0, UNCHECKED},
      '{FUNC_PULSE, CMD_INVERT,     1'b1, 1'b0, UNCHECKED},
      '{FUNC_TICK,  CMD_SPARE_HI,   1'b1, 1'b0, UNCHECKED},
      '{FUNC_CMD,   CMD_TOGGLE,     1'b0, 1'b0, UNCHECKED},
      '{FUNC_CMD,   CMD_INVERT,     1'b0, 1'b0, UNCHECKED},
      '{FUNC_CMD,   CMD_GO_TOP,     1'b0, 1'b0, UNCHECKED}
    };

    settings[0] = '{10'd0, 15'd0, 10'd0, 16'd0};
    settings[1] = '{SETTLE_MAX, 15'h7FFF, 10'h3FF, SAVE_MAX};
    settings[2] = '{10'd2, 15'd6, 10'd2, 16'd12};
    settings[3] = '{10'd1, 15'd40, 10'd5, 16'd3};
    settings[4].settle_ms       = 10'($urandom_range(6, 0));
    settings[4].force_distance  = 15'($urandom_range(80, 0));
    settings[4].ignore_distance = 10'($urandom_range(8, 0));
    settings[4].save_delay_ms   = 16'($urandom_range(40, 0));
    settings[5] = '{10'd4, 15'h7FFF, 10'd1, 16'd25};

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) offer_item(plan[i]);

    for (ph = 0; ph < SETTING_COUNT; ph++) begin
      wait_drained();
      apply_settings(settings[ph]);
      // Hold the result side long enough to back the item channel up.
      if (ph == 3) hold_pending = 1'b1;
      for (n = 0; n < phase_items[ph]; n++) begin
        if (ph == 2 && n == phase_items[ph] / 2) wait_drained();
        offer_item(random_item());
      end
    end
    wait_drained();
    repeat (8) @(posedge clk);

    $display("Run covered %0d input transactions under %0d register settings.",
             items_sent, SETTING_COUNT + 1);
    $display("Checked %0d results: %0d with the motor running, %0d save requests.",
             results_checked, running_seen, saves_seen);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: blind_motor_position_controller_core.f
rtl/core/bmpc_pkg.sv
rtl/core/bmpc_if.sv
rtl/core/bmpc_cfg.sv
rtl/core/bmpc_engine.sv
rtl/core/blind_motor_position_controller_core.sv
rtl/core/bmpc_checker.sv
tb/testbench.sv
